/* rtl/core/mas_pkg.sv */
// Shared types and constants for the magnitude argsort block.
// No dependencies; imported by magnitude_argsort_insertion.
package mas_pkg;

	// Output index port width and direction register width (fixed by the interface)
	localparam int INDEX_OUT_W = 7;
	localparam int DIR_W       = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_EMIT
	} mas_state_t;

endpackage

/* rtl/core/mas_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies; used by magnitude_argsort_insertion for the sorted record store.
module mas_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/magnitude_argsort_insertion.sv */
// Top level of the magnitude argsort block: load, insertion and emit control.
// Depends on mas_pkg (state type, port widths) and mas_ram (record store).
//
// Usage:
//  - Input channel: sample_value/is_last are taken at a rising edge where start
//    is high and busy is low. Each item is one vector element; is_last closes
//    the vector. Items beyond MAX_LENGTH are dropped and flagged as overflow.
//  - Results: after the closing item, one item per stored element is shown for
//    one cycle under result_strobe: the one-based input position (sorted_index)
//    in magnitude order, final_result on the last one, overflowed on all of them
//    if anything was dropped. The receiver cannot stall; results are never held.
//  - Config: cfg_we writes cfg_wdata into the direction register (reset 1):
//    positive ascending, negative descending, zero gives reversed input order.
//    Write only while idle.
//  - Timing: elements are inserted into a sorted list as they arrive (stable
//    insertion, same result as sorting at the end). Element number k (from 0)
//    is accepted, then moves toward the front past one record at a time (at most k)
//    and is then written into its slot. Element 0 and dropped items are done
//    in the accept cycle. The record RAM does one read and one write per
//    cycle, which sets that loop.
//  - Emit reads the stored records out in order through the registered RAM
//    read, so each result follows the emit state and the read register.
//  - Reset: empty vector, no overflow, direction ascending. The RAM is not cleared;
//    only entries below the fill count are ever used.
module magnitude_argsort_insertion #(
	parameter int MAX_LENGTH  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                start,
	output logic                                busy,
	input  logic signed [VALUE_WIDTH-1:0]       sample_value,
	input  logic                                is_last,
	// configuration
	input  logic                                cfg_we,
	input  logic signed [mas_pkg::DIR_W-1:0]    cfg_wdata,
	// results
	output logic                                result_strobe,
	output logic [mas_pkg::INDEX_OUT_W-1:0]     sorted_index,
	output logic                                final_result,
	output logic                                overflowed
);

	import mas_pkg::*;

	localparam int IDX_W = $clog2(MAX_LENGTH);
	localparam int CNT_W = $clog2(MAX_LENGTH + 1);
	localparam int MAG_W = VALUE_WIDTH - 1;
	localparam int REC_W = IDX_W + MAG_W;

	// ---------------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------------
	mas_state_t             state_q, state_d;
	logic [CNT_W-1:0]       count_q, count_d;     // stored elements
	logic                   ovf_q, ovf_d;         // item dropped in this vector
	logic [DIR_W-1:0]       dir_q;
	logic [IDX_W-1:0]       pos_q, pos_d;         // insertion slot being filled
	logic [MAG_W-1:0]       cur_mag_q, cur_mag_d; // element being inserted
	logic [IDX_W-1:0]       cur_idx_q, cur_idx_d;
	logic                   last_q, last_d;       // inserted item closes vector
	logic [IDX_W-1:0]       emit_q, emit_d;       // next record to read out

	// result pipeline, aligned with the RAM read data
	logic                   valid_s1, valid_d;
	logic                   final_s1, final_d;
	logic                   ovf_s1;

	// RAM port signals
	logic                   we;
	logic [IDX_W-1:0]       waddr, raddr;
	logic [REC_W-1:0]       wdata, rdata;

	// ---------------------------------------------------------------------
	// Magnitude of the incoming sample; most negative saturates to max positive
	// ---------------------------------------------------------------------
	logic [VALUE_WIDTH-1:0] neg_val;
	logic [MAG_W-1:0]       in_mag;
	logic                   in_is_min;

	assign neg_val   = -sample_value;
	assign in_is_min = sample_value[VALUE_WIDTH-1] && (sample_value[MAG_W-1:0] == '0);

	always_comb begin
		if (!sample_value[VALUE_WIDTH-1]) begin
			in_mag = sample_value[MAG_W-1:0];
		end else if (in_is_min) begin
			in_mag = '1;
		end else begin
			in_mag = neg_val[MAG_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Compare: does the record ahead of the slot stop the insertion?
	// ---------------------------------------------------------------------
	logic [IDX_W-1:0] prev_idx;
	logic [MAG_W-1:0] prev_mag;
	logic             dir_neg, dir_pos, stop;

	assign prev_idx = rdata[REC_W-1:MAG_W];
	assign prev_mag = rdata[MAG_W-1:0];
	assign dir_neg  = dir_q[1];
	assign dir_pos  = !dir_q[1] && dir_q[0];
	assign stop     = (dir_neg && (prev_mag >= cur_mag_q)) ||
	                  (dir_pos && (prev_mag <= cur_mag_q));

	logic accept;
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// ---------------------------------------------------------------------
	// Next state and RAM control
	// ---------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ovf_d     = ovf_q;
		pos_d     = pos_q;
		cur_mag_d = cur_mag_q;
		cur_idx_d = cur_idx_q;
		last_d    = last_q;
		emit_d    = emit_q;
		valid_d   = 1'b0;
		final_d   = 1'b0;
		we        = 1'b0;
		waddr     = pos_q;
		wdata     = {cur_idx_q, cur_mag_q};
		raddr     = pos_q - IDX_W'(1);

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					last_d = is_last;
					emit_d = '0;
					if (count_q == CNT_W'(MAX_LENGTH)) begin
						// full: drop the item
						ovf_d = 1'b1;
						if (is_last) begin
							state_d = ST_EMIT;
						end
					end else if (count_q == '0) begin
						// first element goes straight to the front
						we      = 1'b1;
						waddr   = '0;
						wdata   = {IDX_W'(0), in_mag};
						count_d = CNT_W'(1);
						if (is_last) begin
							state_d = ST_EMIT;
						end
					end else begin
						cur_mag_d = in_mag;
						cur_idx_d = count_q[IDX_W-1:0];
						pos_d     = count_q[IDX_W-1:0];
						raddr     = count_q[IDX_W-1:0] - IDX_W'(1);
						state_d   = ST_SHIFT;
					end
				end
			end

			ST_SHIFT: begin
				we = 1'b1;
				if (pos_q == '0 || stop) begin
					// drop the element into its slot
					wdata   = {cur_idx_q, cur_mag_q};
					count_d = count_q + CNT_W'(1);
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end else begin
					// move the record ahead one slot back, keep reading forward
					wdata = rdata;
					pos_d = pos_q - IDX_W'(1);
					raddr = pos_q - IDX_W'(2);
				end
			end

			ST_EMIT: begin
				raddr   = emit_q;
				valid_d = 1'b1;
				final_d = (CNT_W'(emit_q) == count_q - CNT_W'(1));
				emit_d  = emit_q + IDX_W'(1);
				if (final_d) begin
					count_d = '0;
					ovf_d   = 1'b0;
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			dir_q    <= DIR_W'(1);
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			ovf_q    <= ovf_d;
			valid_s1 <= valid_d;
			if (cfg_we) begin
				dir_q <= cfg_wdata;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		cur_mag_q <= cur_mag_d;
		cur_idx_q <= cur_idx_d;
		last_q    <= last_d;
		emit_q    <= emit_d;
		final_s1  <= final_d;
		ovf_s1    <= ovf_q;
	end

	// ---------------------------------------------------------------------
	// Record store: {input index, magnitude}, kept in sorted order
	// ---------------------------------------------------------------------
	mas_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_LENGTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ---------------------------------------------------------------------
	// Result ports, straight from the registered read
	// ---------------------------------------------------------------------
	assign result_strobe = valid_s1;
	assign sorted_index  = INDEX_OUT_W'(prev_idx) + INDEX_OUT_W'(1);
	assign final_result  = final_s1;
	assign overflowed    = ovf_s1;

endmodule

/* bench/tb_magnitude_argsort_insertion.sv */
// Self-checking bench for magnitude_argsort_insertion: stable argsort of a vector by |value|.
// Depends on mas_pkg (port widths) and the RTL under rtl/; no files, no arguments.
module tb_magnitude_argsort_insertion;
	timeunit 1ns;
	timeprecision 1ps;
	import mas_pkg::*;

	localparam int MAX_LENGTH     = 64;
	localparam int VALUE_WIDTH    = 32;
	localparam int TOTAL_ITEMS    = 310;
	// settle time covers the worst insertion of a full vector
	localparam int SETTLE_CYCLES  = 72;
	// longest quiet stretch in a correct run is well under this limit
	localparam int WATCHDOG_LIMIT = 4000;

	typedef logic signed [DIR_W-1:0] dir_t;
	localparam dir_t DIR_ASCENDING  = 2'sb01;
	localparam dir_t DIR_DESCENDING = 2'sb11;
	localparam dir_t DIR_REVERSED   = 2'sb00;
	localparam dir_t DIR_MOST_NEG   = 2'sb10;   // reads as -2, still descending

	typedef logic signed [VALUE_WIDTH-1:0] sample_t;
	localparam sample_t MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam sample_t MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

	typedef struct packed {
		logic [INDEX_OUT_W-1:0] index;
		logic                   last_flag;
		logic                   ovf_flag;
	} perm_entry_t;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   start        = 1'b0;
	logic                   busy;
	sample_t                sample_value = '0;
	logic                   is_last      = 1'b0;
	logic                   cfg_we       = 1'b0;
	dir_t                   cfg_wdata    = DIR_ASCENDING;
	logic                   result_strobe;
	logic [INDEX_OUT_W-1:0] sorted_index;
	logic                   final_result;
	logic                   overflowed;

	// expected permutation entries, oldest first
	perm_entry_t perm_expected[$];

	// shadow of the block: stored vector, fill count, drop flag, direction
	sample_t held_values [MAX_LENGTH];
	int      held_count    = 0;
	bit      held_overflow = 1'b0;
	dir_t    cur_dir       = DIR_ASCENDING;

	int error_count = 0;
	int items_sent  = 0;
	int burst_left  = 1;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	magnitude_argsort_insertion #(
		.MAX_LENGTH (MAX_LENGTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample_value (sample_value),
		.is_last      (is_last),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_strobe(result_strobe),
		.sorted_index (sorted_index),
		.final_result (final_result),
		.overflowed   (overflowed)
	);

	// |v|, with the most negative value saturating onto the largest positive one
	function automatic logic [VALUE_WIDTH-1:0] magnitude_of(sample_t v);
		logic [VALUE_WIDTH-1:0] m;
		if (!v[VALUE_WIDTH-1])
			return v;
		m = -v;
		if (m[VALUE_WIDTH-1])
			m = MOST_POS;
		return m;
	endfunction

	// Stable insertion sort of the index list, then queue one entry per element.
	// Zero direction never breaks out of the inner loop: reversed input order.
	task automatic sort_and_expect();
		int                     order [MAX_LENGTH];
		int                     cur;
		int                     j;
		logic [VALUE_WIDTH-1:0] cmag;
		logic [VALUE_WIDTH-1:0] pmag;
		bit                     desc;
		bit                     asc;
		perm_entry_t            e;
		desc = cur_dir[1];
		asc  = !desc && cur_dir[0];
		for (int k = 0; k < held_count; k++)
			order[k] = k;
		for (int k = 1; k < held_count; k++) begin
			cur  = order[k];
			cmag = magnitude_of(held_values[cur]);
			for (j = k; j > 0; j--) begin
				pmag = magnitude_of(held_values[order[j-1]]);
				if (desc && pmag >= cmag)
					break;
				if (asc && pmag <= cmag)
					break;
				order[j] = order[j-1];
			end
			order[j] = cur;
		end
		for (int k = 0; k < held_count; k++) begin
			e.index     = INDEX_OUT_W'(order[k] + 1);
			e.last_flag = (k == held_count - 1);
			e.ovf_flag  = held_overflow;
			perm_expected.push_back(e);
		end
		held_count    = 0;
		held_overflow = 1'b0;
	endtask

	// track one accepted item; items past capacity are dropped but can still close
	task automatic absorb_item(sample_t v, logic last);
		if (held_count < MAX_LENGTH) begin
			held_values[held_count] = v;
			held_count++;
		end else begin
			held_overflow = 1'b1;
		end
		if (last)
			sort_and_expect();
	endtask

	// Present one item and hold it until start && !busy at an edge.
	// Bursts of random length end in random gaps, some of zero length; start stays high inside a burst.
	task automatic send_item(sample_t v, logic last);
		int gap;
		start        <= 1'b1;
		sample_value <= v;
		is_last      <= last;
		do @(posedge clk); while (busy);
		items_sent++;
		absorb_item(v, last);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop sending, let every expected entry arrive, then let the block settle
	task automatic wait_idle();
		start <= 1'b0;
		while (perm_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_direction(dir_t d);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cur_dir = d;
		cfg_we  <= 1'b0;
	endtask

	// biased toward extremes and small magnitudes so ties show up often
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 5))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return sample_t'($urandom_range(0, 6));
			3: return sample_t'(0 - $urandom_range(0, 6));
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic dir_t pick_direction();
		case ($urandom_range(0, 3))
			0: return DIR_ASCENDING;
			1: return DIR_DESCENDING;
			2: return DIR_REVERSED;
			default: return DIR_MOST_NEG;
		endcase
	endfunction

	task automatic send_random_vector(int len);
		for (int i = 0; i < len; i++)
			send_item(pick_sample(), i == len - 1);
	endtask

	// full-scale values, saturating most negative, zero and a +1/-1 tie
	task automatic test_extremes();
		send_item(MOST_NEG, 1'b0);
		send_item(MOST_POS, 1'b0);
		send_item('0, 1'b0);
		send_item(sample_t'(1), 1'b0);
		send_item(sample_t'(-1), 1'b0);
		send_item('0, 1'b1);
	endtask

	task automatic test_single_element();
		send_item(pick_sample(), 1'b1);
	endtask

	// same tie-heavy vector under descending, zero and the -2 pattern
	task automatic test_directions();
		dir_t dirs [3];
		dirs = '{DIR_DESCENDING, DIR_REVERSED, DIR_MOST_NEG};
		foreach (dirs[i]) begin
			set_direction(dirs[i]);
			send_item(sample_t'(5), 1'b0);
			send_item(sample_t'(-5), 1'b0);
			send_item(MOST_POS, 1'b0);
			send_item(MOST_NEG, 1'b0);
			send_item('0, 1'b1);
		end
	endtask

	// exactly MAX_LENGTH elements: full, no drop
	task automatic test_full_capacity();
		set_direction(DIR_DESCENDING);
		send_random_vector(MAX_LENGTH);
	endtask

	// three items past capacity, the closing one among the dropped
	task automatic test_overflow();
		set_direction(DIR_ASCENDING);
		send_random_vector(MAX_LENGTH + 3);
	endtask

	// mostly short vectors, a few long ones, direction changes and full drains between
	task automatic test_random_vectors();
		int len;
		while (items_sent < TOTAL_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2: set_direction(pick_direction());
				3:       wait_idle();
				default: ;
			endcase
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			send_random_vector(len);
		end
	endtask

	// Result checker: the strobe lasts one cycle and cannot be held off, so each
	// edge with the strobe up takes the oldest expected entry.
	always @(posedge clk) begin
		perm_entry_t exp_e;
		if (arst_n && result_strobe) begin
			if (perm_expected.size() == 0) begin
				$display("%0t: unexpected result: expected none, got index %0d final %0b ovf %0b",
				         $time, sorted_index, final_result, overflowed);
				error_count++;
			end else begin
				exp_e = perm_expected.pop_front();
				if (sorted_index !== exp_e.index) begin
					$display("%0t: sorted_index expected %0d got %0d",
					         $time, exp_e.index, sorted_index);
					error_count++;
				end
				if (final_result !== exp_e.last_flag) begin
					$display("%0t: final_result expected %0b got %0b",
					         $time, exp_e.last_flag, final_result);
					error_count++;
				end
				if (overflowed !== exp_e.ovf_flag) begin
					$display("%0t: overflowed expected %0b got %0b",
					         $time, exp_e.ovf_flag, overflowed);
					error_count++;
				end
			end
		end
	end

	// watchdog: cycles without an accepted item or a result
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_single_element();
		test_directions();
		test_full_capacity();
		test_overflow();
		test_random_vectors();

		wait_idle();
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/mas_pkg.sv
rtl/core/mas_ram.sv
rtl/core/magnitude_argsort_insertion.sv
bench/tb_magnitude_argsort_insertion.sv
